FILE: rtl/core/rti_pkg.sv
// Shared constants and types for the ray/triangle intersection core.
package rti_pkg;

    // Default coordinate width of the packed Q10.10 fields.
    localparam int COORD_WIDTH_DEF = 21;

    // Field widths fixed by the stream layout.
    localparam int FIELD_WIDTH  = 21;
    localparam int VERTEX_WIDTH = 63;
    localparam int THR_WIDTH    = 40;
    localparam int DIST_WIDTH   = 32;
    localparam int S_TDATA_W    = 128;
    localparam int M_TDATA_W    = 40;

    // Quotient bits produced by the divider (Q16.16 plus one guard bit).
    localparam int QUOT_BITS = 33;

    // Register reset values and fixed result codes.
    localparam logic [THR_WIDTH-1:0]  DET_THR_RESET = 40'd107374;
    localparam logic [DIST_WIDTH-1:0] MISS_DIST     = 32'hFFFF_0000;
    localparam logic [DIST_WIDTH-1:0] SAT_POS       = 32'h7FFF_FFFF;
    localparam logic [DIST_WIDTH-1:0] SAT_NEG       = 32'h8000_0000;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_VERTEX_A = 2'd0,
        REG_VERTEX_B = 2'd1,
        REG_VERTEX_C = 2'd2,
        REG_DET_THR  = 2'd3
    } cfg_index_t;

endpackage

FILE: rtl/core/ray_triangle_intersect_core.sv
// Pipelined Moller-Trumbore ray/triangle intersection test in exact fixed point.
// Throughput: one ray per cycle while the result side does not stall; the 33-stage
// restoring divider for t sets the depth.
// Back-pressure stalls the whole pipeline; no beat is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits, zeroes the vertices and
// loads the determinant threshold with its default of about 0.0001.
module ray_triangle_intersect_core #(
    parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [rti_pkg::VERTEX_WIDTH-1:0]   cfg_wdata,
    // Ray input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (21 bits each), 2 pad bits
    input  logic [rti_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: hit (1 bit), distance (32 bits), 7 pad bits
    output logic [rti_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int FW   = rti_pkg::FIELD_WIDTH;
    localparam int EW   = CW + 1;              // edge and offset vectors
    localparam int PRW  = CW + EW;             // dir x edge products
    localparam int CRW  = PRW + 1;             // pvec
    localparam int QPW  = 2 * EW;              // tvec x edge products
    localparam int QW   = QPW + 1;             // qvec
    localparam int DOTW = EW + QW + 2;         // dot products, signed
    localparam int QB   = rti_pkg::QUOT_BITS;
    localparam int RW   = DOTW + QB + 1;       // divider remainder width
    localparam int NST  = 7 + QB + 1;          // total pipeline stages

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [rti_pkg::VERTEX_WIDTH-1:0] va_reg, vb_reg, vc_reg;
    logic [rti_pkg::THR_WIDTH-1:0]    thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg  <= '0;
            vb_reg  <= '0;
            vc_reg  <= '0;
            thr_reg <= rti_pkg::DET_THR_RESET;
        end else if (cfg_wr_en) begin
            case (rti_pkg::cfg_index_t'(cfg_index))
                rti_pkg::REG_VERTEX_A: va_reg  <= cfg_wdata;
                rti_pkg::REG_VERTEX_B: vb_reg  <= cfg_wdata;
                rti_pkg::REG_VERTEX_C: vc_reg  <= cfg_wdata;
                rti_pkg::REG_DET_THR:  thr_reg <= cfg_wdata[rti_pkg::THR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: the pipeline moves when the output slot is free or drains.
    logic           en;
    logic [NST-1:0] vld_reg, vld_next;

    assign en       = m_tready || !vld_reg[NST-1];
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];
    assign vld_next = {vld_reg[NST-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack fields and form edges and the origin offset.
    logic signed [CW-1:0] va [3], vb [3], vc [3], org [3], dir [3];
    logic signed [EW-1:0] e1_next [3], e2_next [3], tv_next [3];
    logic signed [CW-1:0] s1_dir_reg [3];
    logic signed [EW-1:0] s1_e1_reg [3], s1_e2_reg [3], s1_tv_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            va[i]  = va_reg[i*CW +: CW];
            vb[i]  = vb_reg[i*CW +: CW];
            vc[i]  = vc_reg[i*CW +: CW];
            org[i] = s_tdata[i*FW +: CW];
            dir[i] = s_tdata[(3+i)*FW +: CW];
            e1_next[i] = EW'(vb[i]) - EW'(va[i]);
            e2_next[i] = EW'(vc[i]) - EW'(va[i]);
            tv_next[i] = EW'(org[i]) - EW'(va[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_dir_reg <= dir;
            s1_e1_reg  <= e1_next;
            s1_e2_reg  <= e2_next;
            s1_tv_reg  <= tv_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross-product partial products for pvec and qvec.
    logic signed [PRW-1:0] s2_pp_reg [6];
    logic signed [QPW-1:0] s2_qp_reg [6];
    logic signed [CW-1:0]  s2_dir_reg [3];
    logic signed [EW-1:0]  s2_e1_reg [3], s2_e2_reg [3], s2_tv_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_pp_reg[0] <= s1_dir_reg[1] * s1_e2_reg[2];
            s2_pp_reg[1] <= s1_dir_reg[2] * s1_e2_reg[1];
            s2_pp_reg[2] <= s1_dir_reg[2] * s1_e2_reg[0];
            s2_pp_reg[3] <= s1_dir_reg[0] * s1_e2_reg[2];
            s2_pp_reg[4] <= s1_dir_reg[0] * s1_e2_reg[1];
            s2_pp_reg[5] <= s1_dir_reg[1] * s1_e2_reg[0];
            s2_qp_reg[0] <= s1_tv_reg[1] * s1_e1_reg[2];
            s2_qp_reg[1] <= s1_tv_reg[2] * s1_e1_reg[1];
            s2_qp_reg[2] <= s1_tv_reg[2] * s1_e1_reg[0];
            s2_qp_reg[3] <= s1_tv_reg[0] * s1_e1_reg[2];
            s2_qp_reg[4] <= s1_tv_reg[0] * s1_e1_reg[1];
            s2_qp_reg[5] <= s1_tv_reg[1] * s1_e1_reg[0];
            s2_dir_reg   <= s1_dir_reg;
            s2_e1_reg    <= s1_e1_reg;
            s2_e2_reg    <= s1_e2_reg;
            s2_tv_reg    <= s1_tv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pvec = dir x e2, qvec = tvec x e1.
    logic signed [CRW-1:0] s3_pv_reg [3];
    logic signed [QW-1:0]  s3_qv_reg [3];
    logic signed [CW-1:0]  s3_dir_reg [3];
    logic signed [EW-1:0]  s3_e1_reg [3], s3_e2_reg [3], s3_tv_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s3_pv_reg[i] <= CRW'(s2_pp_reg[2*i]) - CRW'(s2_pp_reg[2*i+1]);
                s3_qv_reg[i] <= QW'(s2_qp_reg[2*i]) - QW'(s2_qp_reg[2*i+1]);
            end
            s3_dir_reg <= s2_dir_reg;
            s3_e1_reg  <= s2_e1_reg;
            s3_e2_reg  <= s2_e2_reg;
            s3_tv_reg  <= s2_tv_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: products for the four dot products.
    logic signed [EW+CRW-1:0] s4_dp_reg [3], s4_up_reg [3];
    logic signed [CW+QW-1:0]  s4_vp_reg [3];
    logic signed [EW+QW-1:0]  s4_tp_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s4_dp_reg[i] <= s3_e1_reg[i]  * s3_pv_reg[i];
                s4_up_reg[i] <= s3_tv_reg[i]  * s3_pv_reg[i];
                s4_vp_reg[i] <= s3_dir_reg[i] * s3_qv_reg[i];
                s4_tp_reg[i] <= s3_e2_reg[i]  * s3_qv_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: sum the products into det, u, v and t numerators.
    logic signed [DOTW-1:0] s5_det_reg, s5_un_reg, s5_vn_reg, s5_tn_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_det_reg <= DOTW'(s4_dp_reg[0]) + DOTW'(s4_dp_reg[1]) + DOTW'(s4_dp_reg[2]);
            s5_un_reg  <= DOTW'(s4_up_reg[0]) + DOTW'(s4_up_reg[1]) + DOTW'(s4_up_reg[2]);
            s5_vn_reg  <= DOTW'(s4_vp_reg[0]) + DOTW'(s4_vp_reg[1]) + DOTW'(s4_vp_reg[2]);
            s5_tn_reg  <= DOTW'(s4_tp_reg[0]) + DOTW'(s4_tp_reg[1]) + DOTW'(s4_tp_reg[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: fold the sign of det into all terms and run the bound checks.
    logic signed [DOTW-1:0] det_a, un_a, vn_a, tn_a, thr_s;
    logic signed [DOTW:0]   uv_sum;
    logic                   miss_next;
    logic                   s6_hit_reg, s6_neg_reg;
    logic [DOTW-1:0]        s6_det_reg, s6_n_reg;

    always_comb begin
        if (s5_det_reg < 0) begin
            det_a = -s5_det_reg;
            un_a  = -s5_un_reg;
            vn_a  = -s5_vn_reg;
            tn_a  = -s5_tn_reg;
        end else begin
            det_a = s5_det_reg;
            un_a  = s5_un_reg;
            vn_a  = s5_vn_reg;
            tn_a  = s5_tn_reg;
        end
        thr_s     = DOTW'($signed({1'b0, thr_reg}));
        uv_sum    = (DOTW+1)'(un_a) + (DOTW+1)'(vn_a);
        miss_next = (det_a == '0) || (det_a < thr_s) ||
                    (un_a < 0) || (det_a < un_a) ||
                    (vn_a < 0) || ((DOTW+1)'(det_a) < uv_sum);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_hit_reg <= !miss_next;
            s6_neg_reg <= tn_a < 0;
            s6_det_reg <= det_a;
            s6_n_reg   <= (tn_a < 0) ? DOTW'(-tn_a) : DOTW'(tn_a);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: scale the numerator to Q16.16 and flag quotients past 33 bits.
    logic [RW-1:0] n_sh, d_top;
    logic          s7_hit_reg, s7_neg_reg, s7_ovf_reg;
    logic [RW-1:0] s7_r_reg;
    logic [DOTW-1:0] s7_det_reg;

    assign n_sh  = RW'({s6_n_reg, 16'b0});
    assign d_top = RW'(s6_det_reg) << QB;

    always_ff @(posedge aclk) begin
        if (en) begin
            s7_hit_reg <= s6_hit_reg;
            s7_neg_reg <= s6_neg_reg;
            s7_ovf_reg <= n_sh >= d_top;
            s7_r_reg   <= n_sh;
            s7_det_reg <= s6_det_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 8 to 40: restoring divider, one quotient bit per stage, MSB first.
    logic [RW-1:0]   dv_r_reg   [QB];
    logic [QB-1:0]   dv_q_reg   [QB];
    logic [DOTW-1:0] dv_det_reg [QB];
    logic            dv_hit_reg [QB];
    logic            dv_neg_reg [QB];
    logic            dv_ovf_reg [QB];

    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int SH = QB - 1 - k;
        logic [RW-1:0]   r_in, d_sh;
        logic [QB-1:0]   q_in;
        logic [DOTW-1:0] det_in;
        logic            hit_in, neg_in, ovf_in, ge;

        if (k == 0) begin : g_first
            assign r_in   = s7_r_reg;
            assign q_in   = '0;
            assign det_in = s7_det_reg;
            assign hit_in = s7_hit_reg;
            assign neg_in = s7_neg_reg;
            assign ovf_in = s7_ovf_reg;
        end else begin : g_next
            assign r_in   = dv_r_reg[k-1];
            assign q_in   = dv_q_reg[k-1];
            assign det_in = dv_det_reg[k-1];
            assign hit_in = dv_hit_reg[k-1];
            assign neg_in = dv_neg_reg[k-1];
            assign ovf_in = dv_ovf_reg[k-1];
        end

        assign d_sh = RW'(det_in) << SH;
        assign ge   = r_in >= d_sh;

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_r_reg[k]     <= ge ? r_in - d_sh : r_in;
                dv_q_reg[k]     <= q_in | (QB'(ge) << SH);
                dv_det_reg[k]   <= det_in;
                dv_hit_reg[k]   <= hit_in;
                dv_neg_reg[k]   <= neg_in;
                dv_ovf_reg[k]   <= ovf_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 41: saturate, apply the sign and register the result beat.
    logic [QB-1:0]                  q_fin;
    logic [rti_pkg::DIST_WIDTH-1:0] dist_next;
    logic [rti_pkg::DIST_WIDTH-1:0] out_dist_reg;
    logic                           out_hit_reg;

    assign q_fin = dv_q_reg[QB-1];

    always_comb begin
        if (!dv_hit_reg[QB-1]) begin
            dist_next = rti_pkg::MISS_DIST;
        end else if (dv_neg_reg[QB-1]) begin
            if (dv_ovf_reg[QB-1] || q_fin > QB'(rti_pkg::SAT_NEG)) begin
                dist_next = rti_pkg::SAT_NEG;
            end else begin
                dist_next = -q_fin[rti_pkg::DIST_WIDTH-1:0];
            end
        end else begin
            if (dv_ovf_reg[QB-1] || q_fin > QB'(rti_pkg::SAT_POS)) begin
                dist_next = rti_pkg::SAT_POS;
            end else begin
                dist_next = q_fin[rti_pkg::DIST_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_hit_reg  <= dv_hit_reg[QB-1];
            out_dist_reg <= dist_next;
        end
    end

    assign m_tdata = {7'b0, out_dist_reg, out_hit_reg};

endmodule

FILE: rtl/core/rti_checker.sv
// Port-level checker for the ray/triangle intersection core, with its bind.
module rti_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rti_pkg::M_TDATA_W-1:0] m_tdata
);

    // No result beat right after reset.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // A miss always reports a distance of -1.0.
    a_miss_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == rti_pkg::MISS_DIST)
        else $error("miss with wrong distance");

    // The input side is open whenever no result waits.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind ray_triangle_intersect_core rti_checker u_rti_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/tb_top.sv
// Self-checking testbench for the ray/triangle intersection core.
// All phases but the first load a triangle and a determinant threshold while the core is idle.
// Rays are then streamed, directed and random, each result checked against an exact predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    // Exact hit/distance predictor with its own copy of the registers.
    class hit_scoreboard;
        logic [rti_pkg::VERTEX_WIDTH-1:0] vtx[3];
        logic [rti_pkg::THR_WIDTH-1:0]    thr;
        logic                             hit_q[$];
        logic [rti_pkg::DIST_WIDTH-1:0]   dist_q[$];
        int errors, hits, misses, sat_count;

        function new();
            vtx[0] = '0; vtx[1] = '0; vtx[2] = '0;
            thr = rti_pkg::DET_THR_RESET;
        endfunction

        function void set_reg(rti_pkg::cfg_index_t idx,
                              logic [rti_pkg::VERTEX_WIDTH-1:0] val);
            case (idx)
                rti_pkg::REG_VERTEX_A: vtx[0] = val;
                rti_pkg::REG_VERTEX_B: vtx[1] = val;
                rti_pkg::REG_VERTEX_C: vtx[2] = val;
                rti_pkg::REG_DET_THR:  thr = val[rti_pkg::THR_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function wide_t coord(logic [20:0] f);
            return wide_t'(signed'(f));
        endfunction

        // Compute the expected beat for one accepted ray.
        function void note_ray(logic [rti_pkg::S_TDATA_W-1:0] d);
            wide_t va[3], e1[3], e2[3], tv[3], dr[3], pv[3], qv[3];
            wide_t det, un, vn, tn;
            logic [127:0] num, quo;
            logic hit;
            logic [rti_pkg::DIST_WIDTH-1:0] exp_dist;
            hit = 1'b0;
            exp_dist = rti_pkg::MISS_DIST;
            for (int i = 0; i < 3; i++) begin
                va[i] = coord(vtx[0][21*i +: 21]);
                e1[i] = coord(vtx[1][21*i +: 21]) - va[i];
                e2[i] = coord(vtx[2][21*i +: 21]) - va[i];
                tv[i] = coord(d[21*i +: 21]) - va[i];
                dr[i] = coord(d[63 + 21*i +: 21]);
            end
            pv[0] = dr[1]*e2[2] - dr[2]*e2[1];
            pv[1] = dr[2]*e2[0] - dr[0]*e2[2];
            pv[2] = dr[0]*e2[1] - dr[1]*e2[0];
            qv[0] = tv[1]*e1[2] - tv[2]*e1[1];
            qv[1] = tv[2]*e1[0] - tv[0]*e1[2];
            qv[2] = tv[0]*e1[1] - tv[1]*e1[0];
            det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
            un  = tv[0]*pv[0] + tv[1]*pv[1] + tv[2]*pv[2];
            vn  = dr[0]*qv[0] + dr[1]*qv[1] + dr[2]*qv[2];
            tn  = e2[0]*qv[0] + e2[1]*qv[1] + e2[2]*qv[2];
            if (det < 0) begin
                det = -det; un = -un; vn = -vn; tn = -tn;
            end
            // Parallel rejection, then the barycentric bounds, all exact.
            if (det != 0 && det >= wide_t'(thr) && un >= 0 && un <= det
                    && vn >= 0 && un + vn <= det) begin
                hit = 1'b1;
                num = (tn < 0) ? -tn : tn;
                num = num << 16;
                quo = num / det;
                if (tn < 0) begin
                    if (quo > 128'h8000_0000) begin
                        exp_dist = rti_pkg::SAT_NEG; sat_count++;
                    end else exp_dist = rti_pkg::DIST_WIDTH'(-quo);
                end else begin
                    if (quo > 128'h7FFF_FFFF) begin
                        exp_dist = rti_pkg::SAT_POS; sat_count++;
                    end else exp_dist = quo[31:0];
                end
            end
            if (hit) hits++; else misses++;
            hit_q.push_back(hit);
            dist_q.push_back(exp_dist);
        endfunction

        function void check_result(logic [rti_pkg::M_TDATA_W-1:0] d);
            logic h;
            logic [rti_pkg::DIST_WIDTH-1:0] ds;
            if (hit_q.size() == 0) begin
                $error("result beat with no expectation: %h", d);
                errors++;
                return;
            end
            h = hit_q.pop_front();
            ds = dist_q.pop_front();
            if (d[0] !== h) begin
                $error("hit: expected %0d, actual %0d", h, d[0]);
                errors++;
            end
            if (d[32:1] !== ds) begin
                $error("distance: expected %0d, actual %0d", $signed(ds), $signed(d[32:1]));
                errors++;
            end
        endfunction

        function int pending();
            return hit_q.size();
        endfunction
    endclass

    logic aclk, aresetn;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [rti_pkg::VERTEX_WIDTH-1:0] cfg_wdata;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [rti_pkg::S_TDATA_W-1:0] s_tdata;
    logic [rti_pkg::M_TDATA_W-1:0] m_tdata;

    hit_scoreboard sb = new();
    int burst_left = 0;
    int accepted_rays = 0;
    int idle_cycles = 0;

    ray_triangle_intersect_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Result side: stalls on its own pattern, with one long hold to fill the pipeline.
    initial begin
        int cyc;
        int hold;
        bit held;
        cyc = 0;
        hold = 0;
        held = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (!held && accepted_rays >= 200) begin
                hold = 400;
                held = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ((cyc / 500) % 2 == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Check every result beat.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Watchdog on cycles with no beat moving on either side.
    initial begin
        while (idle_cycles < 5000) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one ray; bursts of random length are separated by random gaps.
    task automatic send_ray(logic [rti_pkg::S_TDATA_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_ray(d);
        accepted_rays++;
    endtask

    function automatic logic [rti_pkg::S_TDATA_W-1:0] pack_ray(int ox, int oy, int oz,
                                                               int dx, int dy, int dz);
        return {2'b00, 21'(dz), 21'(dy), 21'(dx), 21'(oz), 21'(oy), 21'(ox)};
    endfunction

    function automatic logic [rti_pkg::VERTEX_WIDTH-1:0] pack_vtx(int x, int y, int z);
        return {21'(z), 21'(y), 21'(x)};
    endfunction

    function automatic int rnd(int r);
        return int'($urandom_range(0, 2*r)) - r;
    endfunction

    task automatic cfg_write(rti_pkg::cfg_index_t idx,
                             logic [rti_pkg::VERTEX_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    // Drain the pipeline before touching the registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic load_triangle(logic [rti_pkg::VERTEX_WIDTH-1:0] a,
                                 logic [rti_pkg::VERTEX_WIDTH-1:0] b,
                                 logic [rti_pkg::VERTEX_WIDTH-1:0] c,
                                 logic [rti_pkg::THR_WIDTH-1:0] t);
        wait_idle();
        cfg_write(rti_pkg::REG_VERTEX_A, a);
        cfg_write(rti_pkg::REG_VERTEX_B, b);
        cfg_write(rti_pkg::REG_VERTEX_C, c);
        cfg_write(rti_pkg::REG_DET_THR, rti_pkg::VERTEX_WIDTH'(t));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int ax, ay, az, bx, by, bz, cx, cy, cz;
        int ox, oy, oz, u, v, px, py, pz, sh;
        logic [rti_pkg::THR_WIDTH-1:0] t;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Degenerate triangle after reset: the determinant is always zero.
        send_ray(pack_ray(0, 0, 1024, 0, 0, -1024));
        send_ray(pack_ray(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575));
        send_ray({2'b00, {126{1'b1}}});

        // Large triangle in z = 0 with no parallel band.
        load_triangle(pack_vtx(-512000, -512000, 0), pack_vtx(512000, -512000, 0),
                      pack_vtx(0, 512000, 0), '0);
        send_ray(pack_ray(0, 0, 1024, 0, 0, -1024));           // t = 1.0
        send_ray(pack_ray(0, 0, 1024000, 0, 0, -1));            // positive saturation
        send_ray(pack_ray(0, 0, -1024000, 0, 0, -1));           // negative saturation
        send_ray(pack_ray(0, 0, -2048, 0, 0, -1024));           // negative t
        send_ray(pack_ray(0, 0, 1024, 1024, 0, 0));             // parallel, zero det
        send_ray(pack_ray(-512000, -512000, 1024, 0, 0, -1024)); // vertex a, U = V = 0
        send_ray(pack_ray(512000, -512000, 1024, 0, 0, -1024));  // U = 1
        send_ray(pack_ray(0, 512000, 1024, 0, 0, -1024));        // V = 1
        send_ray(pack_ray(256000, 0, 1024, 0, 0, -1024));        // on edge b-c
        send_ray(pack_ray(256001, 0, 1024, 0, 0, -1024));        // just outside U + V
        send_ray(pack_ray(0, -512001, 1024, 0, 0, -1024));       // V below zero
        send_ray(pack_ray(-512001, -512000, 1024, 0, 0, -1024)); // U below zero
        send_ray(pack_ray(0, 0, 1048575, 0, 0, -1048576));
        send_ray(pack_ray(0, 0, 1024, 1048575, 1048575, -1048576));

        // Full-scale threshold with a full-range triangle; both rays miss.
        load_triangle(pack_vtx(-1048576, 1048575, 0), pack_vtx(1048575, -1048576, 1048575),
                      pack_vtx(0, 0, -1048576), {rti_pkg::THR_WIDTH{1'b1}});
        send_ray(pack_ray(0, 0, 1024, 0, 0, -1024));
        send_ray(pack_ray(1048575, -1048576, 0, -1048576, 1048575, 0));

        // Random triangles, mostly with rays aimed inside them.
        for (int ph = 0; ph < 6; ph++) begin
            ax = rnd(131072); ay = rnd(131072); az = rnd(131072);
            bx = rnd(131072); by = rnd(131072); bz = rnd(131072);
            cx = rnd(131072); cy = rnd(131072); cz = rnd(131072);
            case (ph % 4)
                0: t = '0;
                1: t = rti_pkg::DET_THR_RESET;
                2: t = rti_pkg::THR_WIDTH'($urandom_range(0, 1 << 30)) << $urandom_range(0, 9);
                default: t = rti_pkg::THR_WIDTH'({$urandom, $urandom});
            endcase
            load_triangle(pack_vtx(ax, ay, az), pack_vtx(bx, by, bz), pack_vtx(cx, cy, cz), t);
            for (int k = 0; k < 115; k++) begin
                if ($urandom_range(0, 9) < 7) begin
                    u = $urandom_range(0, 280);
                    v = $urandom_range(0, 280 - (u > 270 ? 270 : u));
                    px = ax + ((bx - ax) * u + (cx - ax) * v) / 256;
                    py = ay + ((by - ay) * u + (cy - ay) * v) / 256;
                    pz = az + ((bz - az) * u + (cz - az) * v) / 256;
                    ox = rnd(131072); oy = rnd(131072); oz = rnd(131072);
                    sh = $urandom_range(0, 3);
                    if ($urandom_range(0, 3) == 0)
                        send_ray(pack_ray(ox, oy, oz, (ox - px) >>> sh,
                                          (oy - py) >>> sh, (oz - pz) >>> sh));
                    else
                        send_ray(pack_ray(ox, oy, oz, (px - ox) >>> sh,
                                          (py - oy) >>> sh, (pz - oz) >>> sh));
                end else begin
                    send_ray({2'b00, 30'($urandom), $urandom, $urandom, $urandom});
                end
            end
        end

        wait_idle();
        $display("Covered %0d rays over 9 register settings: %0d hits, %0d misses.",
                 accepted_rays, sb.hits, sb.misses);
        $display("Saturated distances: %0d; long result-side hold applied once.",
                 sb.sat_count);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/rti_pkg.sv
rtl/core/ray_triangle_intersect_core.sv
rtl/core/rti_checker.sv
test/tb_top.sv
